// ===== rtl/mfb_pkg.sv =====
// Package for the breadth-first augmenting-path maximum flow core.
// Holds the widths, function codes, sequencer states and the per-vertex record type.
// No dependencies.
package mfb_pkg;

  localparam int MAX_V    = 64;
  localparam int VW       = $clog2(MAX_V);
  localparam int NW       = VW + 1;
  localparam int CAP_W    = 16;
  localparam int ADDR_W   = 2 * VW;
  localparam int SUM_W    = 22;
  localparam int CFG_W    = 7;
  localparam int FUNC_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Record kept for each vertex reached by the search.
  typedef struct packed {
    logic [VW-1:0]    pred;
    logic             back;
    logic [CAP_W-1:0] res;
  } mfb_info_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_FLUSH,
    ST_INIT,
    ST_DEQ,
    ST_DEQ_WAIT,
    ST_FWD,
    ST_BWD,
    ST_CHECK,
    ST_BN_RD,
    ST_BN_EV,
    ST_AUG_RD,
    ST_AUG_FL,
    ST_AUG_WR,
    ST_SUM,
    ST_DONE
  } mfb_state_t;

endpackage

// ===== rtl/max_flow_bfs_augmenting_core.sv =====
// Top level of the breadth-first augmenting-path maximum flow core.
// Depends on mfb_pkg for widths, codes, states and the per-vertex record.
//
// Usage: the input channel (in_valid/in_stall) carries one item with func, from_vertex,
// to_vertex and capacity. A load item writes the capacity of one ordered vertex pair and
// gives no result. A query item reads the flow and capacity of one pair and presents them
// on the output through ST_QUERY and the output register, stalling the input meanwhile.
// A run item first clears all 4096 flow entries, then repeats a breadth-first search from
// vertex 0 and an augmentation along the path found until the sink is unreachable, and
// finally sums the flows out of vertex 0. The search scans one neighbor address at a time
// through the single read port of the capacity and flow memories.
// The result leaves on the output channel (out_valid/out_stall) from an output register;
// loads are still taken while a result waits, runs and queries wait until it is taken.
// After reset the block clears both matrices, holding in_stall high.
// vertex_count is written through cfg_we/cfg_wdata; the user must write it only while the block is idle, unenforced.
module max_flow_bfs_augmenting_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mfb_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mfb_pkg::FUNC_W-1:0] func,
  input  logic [mfb_pkg::VW-1:0]    from_vertex,
  input  logic [mfb_pkg::VW-1:0]    to_vertex,
  input  logic [mfb_pkg::CAP_W-1:0] capacity,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mfb_pkg::SUM_W-1:0] max_flow,
  output logic [mfb_pkg::CAP_W-1:0] edge_flow,
  output logic [mfb_pkg::CAP_W-1:0] edge_capacity
);
  import mfb_pkg::*;

  mfb_state_t state, state_next;

  logic [CFG_W-1:0]  vertex_count;
  logic [NW-1:0]     n;
  logic [VW-1:0]     sink;
  logic [ADDR_W-1:0] clr_addr;
  logic [NW-1:0]     scan_v;
  logic              ev_valid;
  logic [VW-1:0]     ev_v;
  logic [MAX_V-1:0]  visited;
  logic [NW-1:0]     head, tail;
  logic [VW-1:0]     u;
  logic [VW-1:0]     cur_v;
  logic [NW-1:0]     steps;
  logic [CAP_W-1:0]  bn;
  logic [ADDR_W-1:0] aug_addr;
  logic              aug_back;
  logic [VW-1:0]     aug_pred;
  logic [SUM_W-1:0]  total;
  logic              accept, issuing, walk_end;

  // Memories and their ports.
  logic [CAP_W-1:0]  cap_mem  [0:(1<<ADDR_W)-1];
  logic [CAP_W-1:0]  flow_mem [0:(1<<ADDR_W)-1];
  mfb_info_t         info_mem [0:MAX_V-1];
  logic [VW-1:0]     queue_mem[0:MAX_V-1];
  logic              cap_we, flow_we, info_we;
  logic [ADDR_W-1:0] cap_wa, cap_ra, flow_wa, flow_ra;
  logic [CAP_W-1:0]  cap_wd, flow_wd, cap_rd, flow_rd;
  mfb_info_t         info_wd, info_rd;
  logic [VW-1:0]     q_rd;
  logic              visit_fwd, visit_bwd;

  // Clamped vertex count and sink.
  always_comb begin
    if (vertex_count < CFG_W'(2)) begin
      n = NW'(2);
    end else if (vertex_count > CFG_W'(MAX_V)) begin
      n = NW'(MAX_V);
    end else begin
      n = NW'(vertex_count);
    end
  end
  assign sink = VW'(n - NW'(1));

  assign in_stall = (state != ST_IDLE) ||
                    (out_valid && out_stall && (func == FUNC_RUN || func == FUNC_QUERY));
  assign accept   = in_valid && !in_stall;
  assign issuing  = (state == ST_FWD || state == ST_BWD || state == ST_SUM) && (scan_v < n);
  assign walk_end = (cur_v == '0) || (steps == n);

  // A scanned neighbor joins the search when still unvisited and the edge has room.
  assign visit_fwd = ev_valid && (state == ST_FWD) && !visited[ev_v] && (cap_rd > flow_rd);
  assign visit_bwd = ev_valid && (state == ST_BWD) && !visited[ev_v] && (flow_rd != '0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept && func == FUNC_RUN) state_next = ST_FLUSH;
        else if (accept && func == FUNC_QUERY) state_next = ST_QUERY;
      end
      ST_QUERY:    state_next = ST_IDLE;
      ST_FLUSH:    if (clr_addr == '1) state_next = ST_INIT;
      ST_INIT:     state_next = ST_DEQ;
      ST_DEQ:      state_next = ST_DEQ_WAIT;
      ST_DEQ_WAIT: state_next = ST_FWD;
      ST_FWD:      if (scan_v == n && !ev_valid) state_next = ST_BWD;
      ST_BWD:      if (scan_v == n && !ev_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (visited[sink]) state_next = ST_BN_RD;
        else if (head < tail) state_next = ST_DEQ;
        else state_next = ST_SUM;
      end
      ST_BN_RD:    state_next = walk_end ? ST_AUG_RD : ST_BN_EV;
      ST_BN_EV:    state_next = ST_BN_RD;
      ST_AUG_RD:   state_next = walk_end ? ST_INIT : ST_AUG_FL;
      ST_AUG_FL:   state_next = ST_AUG_WR;
      ST_AUG_WR:   state_next = ST_AUG_RD;
      ST_SUM:      if (scan_v == n && !ev_valid) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // Memory port control.
  always_comb begin
    cap_we  = 1'b0;
    cap_wa  = {from_vertex, to_vertex};
    cap_wd  = capacity;
    cap_ra  = {from_vertex, to_vertex};
    flow_we = 1'b0;
    flow_wa = clr_addr;
    flow_wd = '0;
    flow_ra = {from_vertex, to_vertex};
    info_we = visit_fwd || visit_bwd;
    info_wd.pred = u;
    info_wd.back = visit_bwd;
    info_wd.res  = visit_bwd ? flow_rd : CAP_W'(cap_rd - flow_rd);
    case (state)
      ST_CLEAR: begin
        cap_we  = 1'b1;
        cap_wa  = clr_addr;
        cap_wd  = '0;
        flow_we = 1'b1;
      end
      ST_IDLE: begin
        cap_we = accept && (func == FUNC_LOAD);
      end
      ST_FLUSH: begin
        flow_we = 1'b1;
      end
      ST_FWD: begin
        cap_ra  = {u, scan_v[VW-1:0]};
        flow_ra = {u, scan_v[VW-1:0]};
      end
      ST_BWD: begin
        flow_ra = {scan_v[VW-1:0], u};
      end
      ST_SUM: begin
        flow_ra = {VW'(0), scan_v[VW-1:0]};
      end
      ST_AUG_FL: begin
        flow_ra = info_rd.back ? {cur_v, info_rd.pred} : {info_rd.pred, cur_v};
      end
      ST_AUG_WR: begin
        flow_we = 1'b1;
        flow_wa = aug_addr;
        flow_wd = aug_back ? CAP_W'(flow_rd - bn) : CAP_W'(flow_rd + bn);
      end
      default: begin
        cap_we = 1'b0;
      end
    endcase
  end

  // Capacity and flow matrices.
  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[cap_wa] <= cap_wd;
    cap_rd <= cap_mem[cap_ra];
  end

  always_ff @(posedge clk) begin
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    flow_rd <= flow_mem[flow_ra];
  end

  // Per-vertex search records and the search queue.
  always_ff @(posedge clk) begin
    if (info_we) info_mem[ev_v] <= info_wd;
    info_rd <= info_mem[cur_v];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      queue_mem[tail[VW-1:0]] <= ev_v;
    end else if (state == ST_INIT) begin
      queue_mem[0] <= '0;
    end
    q_rd <= queue_mem[head[VW-1:0]];
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      vertex_count <= CFG_W'(2);
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      ev_valid     <= 1'b0;
      scan_v       <= '0;
      head         <= '0;
      tail         <= '0;
      visited      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) vertex_count <= cfg_wdata;

      if (state == ST_CLEAR || state == ST_FLUSH) clr_addr <= ADDR_W'(clr_addr + 1'b1);

      // Scan pipeline: issue one address a cycle, evaluate the registered read in the cycle after.
      ev_valid <= issuing;
      ev_v     <= scan_v[VW-1:0];
      if (state != state_next) scan_v <= '0;
      else if (issuing) scan_v <= NW'(scan_v + 1'b1);

      if (state == ST_INIT) begin
        visited <= MAX_V'(1);
        head    <= '0;
        tail    <= NW'(1);
      end else begin
        if (info_we) begin
          visited[ev_v] <= 1'b1;
          tail          <= NW'(tail + 1'b1);
        end
        if (state == ST_DEQ_WAIT) head <= NW'(head + 1'b1);
      end

      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_QUERY || state == ST_DONE) out_valid <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_QUERY: begin
        max_flow      <= '0;
        edge_flow     <= flow_rd;
        edge_capacity <= cap_rd;
      end
      ST_DONE: begin
        max_flow      <= total;
        edge_flow     <= '0;
        edge_capacity <= '0;
      end
      ST_DEQ_WAIT: u <= q_rd;
      ST_CHECK: begin
        cur_v <= sink;
        steps <= '0;
        bn    <= '1;
        total <= '0;
      end
      ST_BN_RD: begin
        if (walk_end) begin
          cur_v <= sink;
          steps <= '0;
        end
      end
      ST_BN_EV: begin
        if (info_rd.res < bn) bn <= info_rd.res;
        cur_v <= info_rd.pred;
        steps <= NW'(steps + 1'b1);
      end
      ST_AUG_FL: begin
        aug_addr <= flow_ra;
        aug_back <= info_rd.back;
        aug_pred <= info_rd.pred;
      end
      ST_AUG_WR: begin
        cur_v <= aug_pred;
        steps <= NW'(steps + 1'b1);
      end
      ST_SUM: begin
        if (ev_valid) total <= SUM_W'(total + SUM_W'(flow_rd));
      end
      default: begin
        total <= total;
      end
    endcase
  end

  // Checks on the sequencer.
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEQ || state == ST_FWD || state == ST_BWD) |-> head <= tail)
    else $error("queue head passed tail");

  a_source_visited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD || state == ST_BWD) |-> visited[0])
    else $error("source not marked during search");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_QUERY || $past(state) == ST_DONE))
    else $error("result raised outside query or run completion");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR || state == ST_FLUSH) |-> in_stall)
    else $error("input taken during a clearing sweep");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the breadth-first augmenting-path maximum flow core.
// Depends on mfb_pkg and max_flow_bfs_augmenting_core; holds its own flow predictor.
// Loads random graphs, runs max flow and queries edges under random idling and stalls.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;

  // Predicted result of one run or query item.
  typedef struct {
    logic [SUM_W-1:0] total;
    logic [CAP_W-1:0] flow;
    logic [CAP_W-1:0] cap;
  } flow_result_t;

  // Scoreboard: mirrors the capacity and flow matrices and queues expected results.
  class flow_scoreboard;
    logic [CAP_W-1:0] cap_m[MAX_V*MAX_V];
    logic [CAP_W-1:0] flow_m[MAX_V*MAX_V];
    logic [CFG_W-1:0] vcount;
    flow_result_t     pending_q[$];
    int               errors;

    function new();
      foreach (cap_m[i]) begin
        cap_m[i] = '0;
        flow_m[i] = '0;
      end
      vcount = 7'd2;
      errors = 0;
    endfunction

    // Repeated breadth-first search and augmentation; returns flow out of vertex 0.
    function logic [SUM_W-1:0] solve_flow();
      int n, sink, head, tail, u, v, w, steps, bn, total;
      int color[MAX_V];
      int pred[MAX_V];
      bit back[MAX_V];
      int res[MAX_V];
      int q[MAX_V];
      bit found;
      n = (vcount < 2) ? 2 : ((vcount > MAX_V) ? MAX_V : vcount);
      sink = n - 1;
      foreach (flow_m[i]) flow_m[i] = '0;
      forever begin
        for (v = 0; v < n; v++) begin
          color[v] = 0;
          pred[v] = 0;
          back[v] = 0;
          res[v] = 0;
        end
        color[0] = 1;
        q[0] = 0;
        head = 0;
        tail = 1;
        found = 0;
        while (head < tail && !found) begin
          u = q[head];
          head++;
          // Forward edges with spare capacity first, then backward edges with flow.
          for (v = 0; v < n; v++) begin
            if (color[v] == 0 && cap_m[u*MAX_V+v] > flow_m[u*MAX_V+v]) begin
              color[v] = 1;
              pred[v] = u;
              back[v] = 0;
              res[v] = cap_m[u*MAX_V+v] - flow_m[u*MAX_V+v];
              q[tail] = v;
              tail++;
            end
          end
          for (v = 0; v < n; v++) begin
            if (color[v] == 0 && flow_m[v*MAX_V+u] > 0) begin
              color[v] = 1;
              pred[v] = u;
              back[v] = 1;
              res[v] = flow_m[v*MAX_V+u];
              q[tail] = v;
              tail++;
            end
          end
          color[u] = 2;
          if (color[sink] != 0) found = 1;
        end
        if (!found) break;
        // Bottleneck along the path, then push it.
        bn = res[sink];
        v = sink;
        steps = 0;
        while (v != 0 && steps < n) begin
          if (res[v] < bn) bn = res[v];
          v = pred[v];
          steps++;
        end
        v = sink;
        steps = 0;
        while (v != 0 && steps < n) begin
          w = pred[v];
          if (back[v]) flow_m[v*MAX_V+w] = flow_m[v*MAX_V+w] - bn[CAP_W-1:0];
          else flow_m[w*MAX_V+v] = flow_m[w*MAX_V+v] + bn[CAP_W-1:0];
          v = w;
          steps++;
        end
      end
      total = 0;
      for (v = 0; v < n; v++) total += flow_m[v];
      return total[SUM_W-1:0];
    endfunction

    // Notes one accepted input item and queues its result, if any.
    function void note_item(logic [FUNC_W-1:0] f, logic [VW-1:0] fr, logic [VW-1:0] to,
                            logic [CAP_W-1:0] c);
      flow_result_t r;
      r.total = '0;
      r.flow = '0;
      r.cap = '0;
      case (f)
        FUNC_LOAD: cap_m[fr*MAX_V+to] = c;
        FUNC_RUN: begin
          r.total = solve_flow();
          pending_q.push_back(r);
        end
        FUNC_QUERY: begin
          r.flow = flow_m[fr*MAX_V+to];
          r.cap = cap_m[fr*MAX_V+to];
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic [SUM_W-1:0] mf, logic [CAP_W-1:0] ef,
                               logic [CAP_W-1:0] ec);
      flow_result_t r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: max_flow=%0d edge_flow=%0d cap=%0d",
                                   mf, ef, ec);
        return;
      end
      r = pending_q.pop_front();
      if (mf !== r.total || ef !== r.flow || ec !== r.cap) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: max_flow exp %0d got %0d, edge_flow exp %0d got %0d, ",
                    "cap exp %0d got %0d"}, r.total, mf, r.flow, ef, r.cap, ec);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [FUNC_W-1:0] func;
  logic [VW-1:0] from_vertex;
  logic [VW-1:0] to_vertex;
  logic [CAP_W-1:0] capacity;
  logic out_valid;
  logic out_stall;
  logic [SUM_W-1:0] max_flow;
  logic [CAP_W-1:0] edge_flow;
  logic [CAP_W-1:0] edge_capacity;

  flow_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit want_hold;
  int n_eff;

  max_flow_bfs_augmenting_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .from_vertex(from_vertex),
    .to_vertex(to_vertex), .capacity(capacity), .out_valid(out_valid),
    .out_stall(out_stall), .max_flow(max_flow), .edge_flow(edge_flow),
    .edge_capacity(edge_capacity)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (want_hold && !held) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(max_flow, edge_flow, edge_capacity);
  end

  // Offers one item with random idle cycles before it, and waits for acceptance.
  task automatic send_item(logic [FUNC_W-1:0] f, logic [VW-1:0] fr, logic [VW-1:0] to,
                           logic [CAP_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    from_vertex <= fr;
    to_vertex <= to;
    capacity <= c;
    do @(posedge clk); while (in_stall);
    sb.note_item(f, fr, to, c);
  endtask

  // Waits until the block is idle, then writes vertex_count.
  task automatic write_vcount(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.vcount = v;
    n_eff = (v < 2) ? 2 : ((v > MAX_V) ? MAX_V : v);
  endtask

  function automatic logic [CAP_W-1:0] rand_cap();
    case ($urandom_range(3))
      0: return CAP_W'($urandom_range(1, 20));
      1: return CAP_W'($urandom);
      2: return 16'hFFFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_vertex();
    if ($urandom_range(99) < 85) return VW'($urandom_range(n_eff - 1));
    return VW'($urandom_range(MAX_V - 1));
  endfunction

  // One graph: edge loads, a run, then edge queries, with some noise items.
  task automatic graph_round(int n_edges, int n_queries);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(99) < 5)
        send_item(FUNC_NONE, VW'($urandom), VW'($urandom), CAP_W'($urandom));
      send_item(FUNC_LOAD, rand_vertex(), rand_vertex(), rand_cap());
    end
    send_item(FUNC_RUN, VW'($urandom), VW'($urandom), CAP_W'($urandom));
    for (int i = 0; i < n_queries; i++) send_item(FUNC_QUERY, rand_vertex(), rand_vertex(), '0);
  endtask

  initial begin
    int vc_list[12];
    vc_list = '{3, 5, 8, 0, 1, 6, 4, 64, 127, 12, 2, 7};
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_wdata = '0;
    in_valid = 0;
    func = '0;
    from_vertex = '0;
    to_vertex = '0;
    capacity = '0;
    idle_pct = 0;
    stall_pct = 0;
    want_hold = 0;
    n_eff = 2;
    repeat (9) @(posedge clk);
    rst <= 0;
    // Clearing pass after reset keeps the input stalled.
    do @(posedge clk); while (in_stall);
    write_vcount(7'd2);

    // Directed: single full-capacity edge, replacement, out-of-range edge, unknown code.
    send_item(FUNC_RUN, '0, '0, '0);
    send_item(FUNC_LOAD, 6'd0, 6'd1, 16'hFFFF);
    send_item(FUNC_RUN, '0, '0, '0);
    send_item(FUNC_QUERY, 6'd0, 6'd1, '0);
    send_item(FUNC_LOAD, 6'd0, 6'd1, 16'd7);
    send_item(FUNC_LOAD, 6'd63, 6'd63, 16'hFFFF);
    send_item(FUNC_NONE, 6'd63, 6'd0, 16'hFFFF);
    send_item(FUNC_RUN, '0, '0, '0);
    send_item(FUNC_QUERY, 6'd0, 6'd1, '0);
    send_item(FUNC_QUERY, 6'd63, 6'd63, '0);
    // Four-vertex graph with a cross edge in each direction between vertices 1 and 2.
    write_vcount(7'd4);
    send_item(FUNC_LOAD, 6'd0, 6'd1, 16'd10);
    send_item(FUNC_LOAD, 6'd0, 6'd2, 16'd10);
    send_item(FUNC_LOAD, 6'd1, 6'd2, 16'd5);
    send_item(FUNC_LOAD, 6'd1, 6'd3, 16'd5);
    send_item(FUNC_LOAD, 6'd2, 6'd3, 16'd15);
    send_item(FUNC_LOAD, 6'd2, 6'd1, 16'd3);
    send_item(FUNC_RUN, '0, '0, '0);
    send_item(FUNC_QUERY, 6'd1, 6'd2, '0);
    send_item(FUNC_QUERY, 6'd2, 6'd3, '0);
    send_item(FUNC_QUERY, 6'd0, 6'd0, '0);

    // Random phases over several vertex counts and idling mixes.
    for (int p = 0; p < 12; p++) begin
      write_vcount(CFG_W'(vc_list[p]));
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 55; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 55; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (n_eff >= MAX_V) begin
        // Sparse large graph with a short chain to the sink.
        send_item(FUNC_LOAD, 6'd0, 6'd33, rand_cap() | 16'd1);
        send_item(FUNC_LOAD, 6'd33, 6'd63, rand_cap() | 16'd1);
        graph_round(8, 15);
        graph_round(6, 15);
      end else begin
        for (int e = 0; e < 4; e++) graph_round($urandom_range(4, 10), $urandom_range(2, 5));
      end
      if (p == 1) begin
        // Long receiver hold-off while queries keep arriving.
        want_hold = 1;
        for (int i = 0; i < 15; i++) send_item(FUNC_QUERY, rand_vertex(), rand_vertex(), '0);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mfb_pkg.sv
rtl/max_flow_bfs_augmenting_core.sv
tb/testbench.sv
